FILE: rtl/hrp_pkg.sv
// Shared types, codes and constants of the request header parser.
`default_nettype none
package hrp_pkg;

  // Field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned RoleW    = 3;
  localparam int unsigned MethodW  = 4;
  localparam int unsigned VersionW = 2;
  localparam int unsigned ErrorW   = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;

  // Method buffer: up to seven upper-cased letters, first letter in the low byte
  localparam int unsigned MaxMethodLen = 7;
  localparam int unsigned MethodLenW   = 4;
  localparam int unsigned MethodBufW   = 56;
  localparam int unsigned NumMethods   = 9;
  localparam int unsigned HostPosW     = 3;

  // Known methods, zero padded, first letter in the low byte
  localparam logic [MethodBufW-1:0] MethodNames [NumMethods] = '{
    56'h00000000544547,   // GET
    56'h00000044414548,   // HEAD
    56'h00000054534F50,   // POST
    56'h00000000545550,   // PUT
    56'h004554454C4544,   // DELETE
    56'h5443454E4E4F43,   // CONNECT
    56'h534E4F4954504F,   // OPTIONS
    56'h00004543415254,   // TRACE
    56'h00004843544150    // PATCH
  };

  // Header key "host", first letter in the low byte
  localparam logic [31:0] HostKey = 32'h74736F68;
  localparam logic [HostPosW-1:0] HostFull = 3'd4;
  localparam logic [HostPosW-1:0] HostMiss = 3'd5;

  // Characters
  localparam logic [ByteW-1:0] ChSpace = 8'd32;
  localparam logic [ByteW-1:0] ChCr    = 8'd13;
  localparam logic [ByteW-1:0] ChLf    = 8'd10;
  localparam logic [ByteW-1:0] ChColon = 8'h3A;
  localparam logic [ByteW-1:0] ChDot   = 8'h2E;
  localparam logic [ByteW-1:0] ChSlash = 8'h2F;
  localparam logic [ByteW-1:0] ChDash  = 8'h2D;
  localparam logic [ByteW-1:0] ChH     = 8'h48;
  localparam logic [ByteW-1:0] ChT     = 8'h54;
  localparam logic [ByteW-1:0] ChP     = 8'h50;

  // Status codes
  localparam logic [StatusW-1:0] StatBusy  = 2'd0;
  localparam logic [StatusW-1:0] StatDone  = 2'd1;
  localparam logic [StatusW-1:0] StatError = 2'd2;

  // Byte roles
  localparam logic [RoleW-1:0] RoleSkip    = 3'd0;
  localparam logic [RoleW-1:0] RoleMethod  = 3'd1;
  localparam logic [RoleW-1:0] RoleUrl     = 3'd2;
  localparam logic [RoleW-1:0] RoleVersion = 3'd3;
  localparam logic [RoleW-1:0] RoleKey     = 3'd4;
  localparam logic [RoleW-1:0] RoleValue   = 3'd5;

  // Error causes
  localparam logic [ErrorW-1:0] ErrNone       = 4'd0;
  localparam logic [ErrorW-1:0] ErrMethodChar = 4'd1;
  localparam logic [ErrorW-1:0] ErrMethodUnk  = 4'd2;
  localparam logic [ErrorW-1:0] ErrUrlChar    = 4'd3;
  localparam logic [ErrorW-1:0] ErrVerChar    = 4'd4;
  localparam logic [ErrorW-1:0] ErrVerLiteral = 4'd5;
  localparam logic [ErrorW-1:0] ErrVerDigits  = 4'd6;
  localparam logic [ErrorW-1:0] ErrReqLineEnd = 4'd7;
  localparam logic [ErrorW-1:0] ErrKeyChar    = 4'd8;
  localparam logic [ErrorW-1:0] ErrHdrLineEnd = 4'd9;
  localparam logic [ErrorW-1:0] ErrHdrEnd     = 4'd10;
  localparam logic [ErrorW-1:0] ErrNoHost     = 4'd11;

  // Version codes
  localparam logic [VersionW-1:0] Ver10 = 2'd1;
  localparam logic [VersionW-1:0] Ver11 = 2'd2;
  localparam logic [VersionW-1:0] Ver20 = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMethodEnable  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgVersionEnable = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRequireHost   = 2'd2;

  typedef struct packed {
    logic [NumMethods-1:0] method_enable;
    logic [2:0]            version_enable;
    logic                  require_host;
  } cfg_t;

  typedef struct packed {
    logic             is_alpha;
    logic             is_digit;
    logic             is_alnum;
    logic             is_space;
    logic             is_sp;
    logic             is_cr;
    logic             is_lf;
    logic             is_colon;
    logic             is_dot;
    logic             is_slash;
    logic             is_dash;
    logic             url_ok;
    logic [ByteW-1:0] upper;
    logic [ByteW-1:0] lower;
  } char_class_t;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic [RoleW-1:0]    byte_role;
    logic [MethodW-1:0]  method_code;
    logic [VersionW-1:0] version_code;
    logic                header_end;
    logic [ErrorW-1:0]   error_cause;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/hrp_if.sv
// Handshake channels of the request header parser: byte in, result out, config write.
`default_nettype none
interface hrp_in_if;
  logic                    valid;
  logic                    ready;
  logic [hrp_pkg::ByteW-1:0] data_byte;
  logic                    start_req;

  modport source (output valid, data_byte, start_req, input ready);
  modport sink   (input valid, data_byte, start_req, output ready);
endinterface

interface hrp_out_if;
  logic                         valid;
  logic                         ready;
  logic [hrp_pkg::StatusW-1:0]  status;
  logic [hrp_pkg::RoleW-1:0]    byte_role;
  logic [hrp_pkg::MethodW-1:0]  method_code;
  logic [hrp_pkg::VersionW-1:0] version_code;
  logic                         header_end;
  logic [hrp_pkg::ErrorW-1:0]   error_cause;

  modport source (output valid, status, byte_role, method_code, version_code, header_end,
                  error_cause, input ready);
  modport sink   (input valid, status, byte_role, method_code, version_code, header_end,
                  error_cause, output ready);
endinterface

interface hrp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [hrp_pkg::CfgIdxW-1:0]  index;
  logic [hrp_pkg::CfgDataW-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

FILE: rtl/http_request_header_parser_top.sv
// Top level of the request header parser: input register, parse step, result register, config.
// One request byte per item and one result item per byte. The block takes a new item in every
// cycle while it is not stalled; the byte is held in the input register and is parsed into the
// result register, which holds it until it is taken. The parse-state transition is combinational
// and is registered with each parsed byte, so each byte sees the state the previous byte left.
// Items stall only when the result register is full and its consumer does not take the result.
// Configuration writes are always taken and apply to bytes parsed afterwards; there is no
// clearing pass after reset.
`default_nettype none
module http_request_header_parser_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  hrp_in_if.sink       in_if,
  hrp_out_if.source    out_if,
  hrp_cfg_if.sink      cfg_if
);
  import hrp_pkg::*;

  logic             s1_valid_q, s1_valid_d;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_start_q;
  logic             out_valid_q, out_valid_d;
  result_t          out_q;
  result_t          step_res;
  cfg_t             cfg_q;
  logic             out_free, advance, in_acc;

  // Pipeline flow control
  assign out_free    = !out_valid_q || out_if.ready;
  assign advance     = s1_valid_q && out_free;
  assign in_if.ready = !s1_valid_q || out_free;
  assign in_acc      = in_if.valid && in_if.ready;
  assign s1_valid_d  = in_acc || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_if.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the incoming item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q  <= in_if.data_byte;
      s1_start_q <= in_if.start_req;
    end
  end

  hrp_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .byte_i    (s1_byte_q),
    .start_i   (s1_start_q),
    .cfg_i     (cfg_q),
    .res_o     (step_res)
  );

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.status       = out_q.status;
  assign out_if.byte_role    = out_q.byte_role;
  assign out_if.method_code  = out_q.method_code;
  assign out_if.version_code = out_q.version_code;
  assign out_if.header_end   = out_q.header_end;
  assign out_if.error_cause  = out_q.error_cause;

  // Configuration registers; writes to unknown indexes are dropped
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.method_enable  <= '1;
      cfg_q.version_enable <= 3'd3;
      cfg_q.require_host   <= 1'b1;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CfgMethodEnable:  cfg_q.method_enable  <= cfg_if.wdata[NumMethods-1:0];
        CfgVersionEnable: cfg_q.version_enable <= cfg_if.wdata[2:0];
        CfgRequireHost:   cfg_q.require_host   <= cfg_if.wdata[0];
        default: begin
          // unknown register
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/hrp_char_class.sv
// Character classifier: letter, digit, whitespace, URL class and case folding of one byte.
`default_nettype none
module hrp_char_class (
  input  logic [hrp_pkg::ByteW-1:0] byte_i,
  output hrp_pkg::char_class_t      cc_o
);
  import hrp_pkg::*;

  logic is_up, is_lo, url_special;

  always_comb begin
    is_up = (byte_i >= 8'h41) && (byte_i <= 8'h5A);
    is_lo = (byte_i >= 8'h61) && (byte_i <= 8'h7A);

    // Punctuation allowed in a URL besides letters and digits
    unique case (byte_i)
      8'h2D, 8'h2E, 8'h5F, 8'h7E, 8'h3A, 8'h2F, 8'h3F, 8'h23,
      8'h5B, 8'h5D, 8'h40, 8'h21, 8'h24, 8'h26, 8'h27, 8'h28,
      8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D: url_special = 1'b1;
      default:                                 url_special = 1'b0;
    endcase

    cc_o.is_alpha = is_up || is_lo;
    cc_o.is_digit = (byte_i >= 8'h30) && (byte_i <= 8'h39);
    cc_o.is_alnum = cc_o.is_alpha || cc_o.is_digit;
    cc_o.is_sp    = (byte_i == ChSpace);
    cc_o.is_space = cc_o.is_sp || ((byte_i >= 8'd9) && (byte_i <= 8'd13));
    cc_o.is_cr    = (byte_i == ChCr);
    cc_o.is_lf    = (byte_i == ChLf);
    cc_o.is_colon = (byte_i == ChColon);
    cc_o.is_dot   = (byte_i == ChDot);
    cc_o.is_slash = (byte_i == ChSlash);
    cc_o.is_dash  = (byte_i == ChDash);
    cc_o.url_ok   = cc_o.is_alnum || url_special;
    cc_o.upper    = is_lo ? byte_i - 8'd32 : byte_i;
    cc_o.lower    = is_up ? byte_i + 8'd32 : byte_i;
  end

endmodule
`default_nettype wire

FILE: rtl/hrp_step.sv
// Parse state and the combinational transition taken for each byte.
`default_nettype none
module hrp_step (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      advance_i,
  input  logic [hrp_pkg::ByteW-1:0] byte_i,
  input  logic                      start_i,
  input  hrp_pkg::cfg_t             cfg_i,
  output hrp_pkg::result_t          res_o
);
  import hrp_pkg::*;

  typedef enum logic [4:0] {
    StMethod,
    StUrl,
    StVersion,
    StVT1,
    StVT2,
    StVP,
    StVSlash,
    StVMajor,
    StVDot,
    StVMinor,
    StLineEnd,
    StHKey,
    StHValue,
    StHLf,
    StEndLf,
    StDone,
    StError
  } state_e;

  char_class_t cc;

  state_e                  st_q, st_d, cur_st;
  logic [MethodBufW-1:0]   buf_q, buf_d, cur_buf;
  logic [MethodLenW-1:0]   len_q, len_d, cur_len;
  logic                    url_q, url_d, cur_url;
  logic [3:0]              major_q, major_d, cur_major;
  logic [HostPosW-1:0]     hpos_q, hpos_d, cur_hpos;
  logic                    host_q, host_d, cur_host;
  logic [MethodW-1:0]      meth_q, meth_d, cur_meth;
  logic [VersionW-1:0]     ver_q, ver_d, cur_ver;
  logic [ErrorW-1:0]       err_q, err_d, cur_err;

  logic [MethodW-1:0]      method_hit;
  logic [VersionW-1:0]     ver_hit;
  logic [ByteW-1:0]        want;
  logic [ByteW-1:0]        host_ch;
  logic [RoleW-1:0]        role;
  logic                    hend;

  hrp_char_class u_class (
    .byte_i (byte_i),
    .cc_o   (cc)
  );

  // Drop the held parse state when a new request starts on this byte
  always_comb begin
    cur_st    = start_i ? StMethod : st_q;
    cur_buf   = start_i ? '0 : buf_q;
    cur_len   = start_i ? '0 : len_q;
    cur_url   = start_i ? 1'b0 : url_q;
    cur_major = start_i ? '0 : major_q;
    cur_hpos  = start_i ? '0 : hpos_q;
    cur_host  = start_i ? 1'b0 : host_q;
    cur_meth  = start_i ? '0 : meth_q;
    cur_ver   = start_i ? '0 : ver_q;
    cur_err   = start_i ? ErrNone : err_q;
  end

  // Compare the buffered method with all known methods at once
  always_comb begin
    method_hit = '0;
    for (int m = 0; m < NumMethods; m++) begin
      if ((cur_buf == MethodNames[m]) && (cur_len <= MethodLenW'(MaxMethodLen)) &&
          cfg_i.method_enable[m]) begin
        method_hit = MethodW'(m + 1);
      end
    end
  end

  // Map major and minor digits to a version code, zero when unknown or disabled
  always_comb begin
    ver_hit = '0;
    if (cur_major == 4'd1 && byte_i[3:0] == 4'd0 && cfg_i.version_enable[0]) begin
      ver_hit = Ver10;
    end else if (cur_major == 4'd1 && byte_i[3:0] == 4'd1 && cfg_i.version_enable[1]) begin
      ver_hit = Ver11;
    end else if (cur_major == 4'd2 && byte_i[3:0] == 4'd0 && cfg_i.version_enable[2]) begin
      ver_hit = Ver20;
    end
  end

  assign host_ch = HostKey[{cur_hpos[1:0], 3'b000} +: 8];

  // Character expected in the literal part of the version
  always_comb begin
    unique case (cur_st)
      StVP:     want = ChP;
      StVSlash: want = ChSlash;
      default:  want = ChT;
    endcase
  end

  // Transition for one byte
  always_comb begin
    st_d    = cur_st;
    buf_d   = cur_buf;
    len_d   = cur_len;
    url_d   = cur_url;
    major_d = cur_major;
    hpos_d  = cur_hpos;
    host_d  = cur_host;
    meth_d  = cur_meth;
    ver_d   = cur_ver;
    err_d   = cur_err;
    role    = RoleSkip;
    hend    = 1'b0;

    unique case (cur_st)
      StMethod: begin
        if (cc.is_sp && cur_len != '0) begin
          if (method_hit == '0) begin
            st_d  = StError;
            err_d = ErrMethodUnk;
          end else begin
            meth_d = method_hit;
            st_d   = StUrl;
          end
        end else if (cc.is_space && cur_len == '0) begin
          // skip leading whitespace
        end else if (cc.is_alpha) begin
          if (cur_len < MethodLenW'(MaxMethodLen)) begin
            buf_d[{cur_len[2:0], 3'b000} +: 8] = cc.upper;
          end
          if (cur_len <= MethodLenW'(MaxMethodLen)) begin
            len_d = cur_len + 1'b1;
          end
          role = RoleMethod;
        end else begin
          st_d  = StError;
          err_d = ErrMethodChar;
        end
      end
      StUrl: begin
        if (cc.is_sp && cur_url) begin
          st_d = StVersion;
        end else if (cc.is_space && !cur_url) begin
          // skip leading whitespace
        end else if (cc.url_ok) begin
          url_d = 1'b1;
          role  = RoleUrl;
        end else begin
          st_d  = StError;
          err_d = ErrUrlChar;
        end
      end
      StVersion: begin
        if (cc.is_space && !cc.is_sp) begin
          st_d  = StError;
          err_d = ErrVerChar;
        end else if (cc.is_sp) begin
          // skip spaces
        end else if (cc.is_alnum || cc.is_dot || cc.is_slash) begin
          if (cc.upper == ChH) begin
            st_d = StVT1;
            role = RoleVersion;
          end else begin
            st_d  = StError;
            err_d = ErrVerLiteral;
          end
        end else begin
          st_d  = StError;
          err_d = ErrVerChar;
        end
      end
      StVT1, StVT2, StVP, StVSlash: begin
        if (cc.upper == want) begin
          unique case (cur_st)
            StVT1:   st_d = StVT2;
            StVT2:   st_d = StVP;
            StVP:    st_d = StVSlash;
            default: st_d = StVMajor;
          endcase
          role = RoleVersion;
        end else begin
          st_d  = StError;
          err_d = ErrVerLiteral;
        end
      end
      StVMajor: begin
        if (cc.is_digit) begin
          major_d = byte_i[3:0];
          st_d    = StVDot;
          role    = RoleVersion;
        end else begin
          st_d  = StError;
          err_d = ErrVerDigits;
        end
      end
      StVDot: begin
        if (cc.is_dot) begin
          st_d = StVMinor;
          role = RoleVersion;
        end else begin
          st_d  = StError;
          err_d = ErrVerDigits;
        end
      end
      StVMinor: begin
        if (cc.is_digit && ver_hit != '0) begin
          ver_d = ver_hit;
          st_d  = StLineEnd;
          role  = RoleVersion;
        end else begin
          st_d  = StError;
          err_d = ErrVerDigits;
        end
      end
      StLineEnd: begin
        if (cc.is_sp || cc.is_cr) begin
          // skip
        end else if (cc.is_lf) begin
          st_d   = StHKey;
          hpos_d = '0;
        end else begin
          st_d  = StError;
          err_d = ErrReqLineEnd;
        end
      end
      StHKey: begin
        if (cc.is_cr) begin
          st_d = StEndLf;
        end else if (cc.is_colon) begin
          st_d = StHValue;
        end else if (cc.is_alnum || cc.is_dash) begin
          if (cur_hpos < HostFull && cc.lower == host_ch) begin
            hpos_d = cur_hpos + 1'b1;
          end else begin
            hpos_d = HostMiss;
          end
          role = RoleKey;
        end else begin
          st_d  = StError;
          err_d = ErrKeyChar;
        end
      end
      StHValue: begin
        if (cc.is_cr) begin
          st_d = StHLf;
        end else if (!cc.is_sp) begin
          role = RoleValue;
        end
      end
      StHLf: begin
        if (cc.is_lf) begin
          if (cur_hpos == HostFull) begin
            host_d = 1'b1;
          end
          hpos_d = '0;
          hend   = 1'b1;
          st_d   = StHKey;
        end else begin
          st_d  = StError;
          err_d = ErrHdrLineEnd;
        end
      end
      StEndLf: begin
        if (cc.is_lf) begin
          if (cfg_i.require_host && !cur_host) begin
            st_d  = StError;
            err_d = ErrNoHost;
          end else begin
            st_d = StDone;
          end
        end else begin
          st_d  = StError;
          err_d = ErrHdrEnd;
        end
      end
      default: begin
        // done or error: hold until the next request starts
      end
    endcase
  end

  // Result of this byte
  always_comb begin
    res_o.status       = (st_d == StDone) ? StatDone :
                         (st_d == StError) ? StatError : StatBusy;
    res_o.byte_role    = role;
    res_o.method_code  = meth_d;
    res_o.version_code = ver_d;
    res_o.header_end   = hend;
    res_o.error_cause  = (st_d == StError) ? err_d : ErrNone;
  end

  // Hold the parse state, advance once per byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StMethod;
      buf_q   <= '0;
      len_q   <= '0;
      url_q   <= 1'b0;
      major_q <= '0;
      hpos_q  <= '0;
      host_q  <= 1'b0;
      meth_q  <= '0;
      ver_q   <= '0;
      err_q   <= ErrNone;
    end else if (advance_i) begin
      st_q    <= st_d;
      buf_q   <= buf_d;
      len_q   <= len_d;
      url_q   <= url_d;
      major_q <= major_d;
      hpos_q  <= hpos_d;
      host_q  <= host_d;
      meth_q  <= meth_d;
      ver_q   <= ver_d;
      err_q   <= err_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/hrp_checker.sv
// Port-level checks of the request header parser and their binding to the top level.
`default_nettype none
module hrp_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [hrp_pkg::StatusW-1:0]  status_i,
  input  logic [hrp_pkg::RoleW-1:0]    byte_role_i,
  input  logic [hrp_pkg::MethodW-1:0]  method_code_i,
  input  logic [hrp_pkg::VersionW-1:0] version_code_i,
  input  logic                         header_end_i,
  input  logic [hrp_pkg::ErrorW-1:0]   error_cause_i
);
  import hrp_pkg::*;

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
    $stable(error_cause_i) && $stable(byte_role_i))
    else $error("result changed while stalled");

  // An error cause is reported exactly when the status is error
  a_err_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((status_i == StatError) == (error_cause_i != ErrNone)))
    else $error("error cause and status disagree");

  // A finished or failed request gives its byte no role and ends no header line
  a_final_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != StatBusy) |-> (byte_role_i == RoleSkip) && !header_end_i)
    else $error("role on a final byte");

  // A complete request carries a method and a version
  a_done_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == StatDone) |-> (method_code_i != '0) && (version_code_i != '0))
    else $error("complete request without method or version");

  // A header line can only end once method and version are known
  a_hend_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && header_end_i |-> (method_code_i != '0) && (version_code_i != '0))
    else $error("header line ended before the request line");

endmodule

bind http_request_header_parser_top hrp_checker u_hrp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_if.valid),
  .out_ready_i    (out_if.ready),
  .status_i       (out_if.status),
  .byte_role_i    (out_if.byte_role),
  .method_code_i  (out_if.method_code),
  .version_code_i (out_if.version_code),
  .header_end_i   (out_if.header_end),
  .error_cause_i  (out_if.error_cause)
);
`default_nettype wire
